@@ rtl/feeder_shot_sequencer_macros.svh @@
`ifndef FEEDER_SHOT_SEQUENCER_MACROS_SVH
`define FEEDER_SHOT_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fss_pkg.sv @@
package fss_pkg;

    localparam int TICK_COUNTER_BITS_DEF = 16;
    localparam int THR_W                 = 16;
    localparam int CFG_DATA_W            = 31;
    localparam int CFG_INDEX_W           = 3;
    localparam int POS_W                 = 32;
    localparam int SPD_W                 = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRE_PERIOD_TICKS  = 3'd0,
        CFG_FEED_STEP          = 3'd1,
        CFG_POSITION_TOLERANCE = 3'd2,
        CFG_SPEED_TOLERANCE    = 3'd3,
        CFG_JAM_SPEED_LIMIT    = 3'd4,
        CFG_JAM_DWELL          = 3'd5,
        CFG_UNJAM_SPAN         = 3'd6,
        CFG_UNJAM_TORQUE       = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FEED  = 2'd1,
        PH_UNJAM = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DM_ZERO  = 2'd0,
        DM_HOLD  = 2'd1,
        DM_UNJAM = 2'd2,
        DM_NONE  = 2'd3
    } t_drive_mode;

    typedef struct packed {
        logic [THR_W-1:0] fire_period_ticks;
        logic [30:0]      feed_step;
        logic [30:0]      position_tolerance;
        logic [14:0]      speed_tolerance;
        logic [14:0]      jam_speed_limit;
        logic [THR_W-1:0] jam_dwell;
        logic [THR_W-1:0] unjam_span;
    } t_cfg;

    localparam logic [THR_W-1:0] FIRE_PERIOD_TICKS_RST  = 16'd100;
    localparam logic [30:0]      FEED_STEP_RST          = 31'd8192;
    localparam logic [30:0]      POSITION_TOLERANCE_RST = 31'd655;
    localparam logic [14:0]      SPEED_TOLERANCE_RST    = 15'd256;
    localparam logic [14:0]      JAM_SPEED_LIMIT_RST    = 15'd128;
    localparam logic [THR_W-1:0] JAM_DWELL_RST          = 16'd200;
    localparam logic [THR_W-1:0] UNJAM_SPAN_RST         = 16'd100;

endpackage

@@ rtl/feeder_shot_sequencer.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready    | disarm, friction_on, feeder_armed,
//          |                            | shot_request, burst_enable, position, speed
// out      | o_out_valid / i_out_ready  | drive_mode, drive_target, wheels_run,
//          |                            | seq_state
// cfg      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result is not stalled; an item that is taken
// passes the input register, then the phase machine and counters into the result register.
// Reset is synchronous; it clears the state and loads the register defaults.
// A stalled result holds; the input register still takes one more item behind it.
`include "feeder_shot_sequencer_macros.svh"

module feeder_shot_sequencer #(
    parameter int TICK_COUNTER_BITS = fss_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_disarm,
    input  logic                                  i_friction_on,
    input  logic                                  i_feeder_armed,
    input  logic                                  i_shot_request,
    input  logic                                  i_burst_enable,
    input  logic signed [fss_pkg::POS_W-1:0]      i_measured_position,
    input  logic signed [fss_pkg::SPD_W-1:0]      i_measured_speed,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic        [1:0]                     o_drive_mode,
    output logic signed [fss_pkg::POS_W-1:0]      o_drive_target,
    output logic                                  o_wheels_run,
    output logic        [1:0]                     o_seq_state,
    input  logic                                  i_cfg_we,
    input  logic        [fss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic        [fss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW    = TICK_COUNTER_BITS;
    localparam int CMP_W = (CW > fss_pkg::THR_W) ? CW : fss_pkg::THR_W;
    localparam int PW    = fss_pkg::POS_W;
    localparam int SW    = fss_pkg::SPD_W;

    fss_pkg::t_cfg cfg;

    fss_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    logic                 r_in_valid;
    logic                 r_in_disarm;
    logic                 r_in_friction;
    logic                 r_in_armed;
    logic                 r_in_shot;
    logic                 r_in_burst;
    logic [PW-1:0]        r_in_position;
    logic signed [SW-1:0] r_in_speed;

    // sequencer state
    fss_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0]   r_target, n_target;
    logic [CW-1:0]   r_fire_timer, n_fire_timer;
    logic            r_pending, n_pending;
    logic [CW-1:0]   r_stall, n_stall;
    logic [CW-1:0]   r_unjam, n_unjam;

    // result register
    logic                 r_out_valid;
    fss_pkg::t_drive_mode r_out_mode, n_out_mode;
    logic [PW-1:0]        r_out_target, n_out_target;
    logic                 r_out_wheels;
    fss_pkg::t_phase      r_out_state;

    logic c_advance;
    logic c_in_take;

    // shared conditions
    logic          c_burst_arm;
    logic [CW-1:0] c_fire_inc;
    logic          c_fire;
    logic          c_trig_now;
    logic          c_pend_tmr;
    logic          c_run_ok;
    logic [SW-1:0] c_spd_mag;
    logic [PW-1:0] c_err;
    logic signed [PW:0] c_err_x;
    logic signed [PW:0] c_tol_x;
    logic signed [PW:0] c_tol_neg;
    logic          c_arrive;
    logic [CW-1:0] c_stall_inc;
    logic [CW-1:0] c_stall_next;
    logic          c_jam;
    logic [CW-1:0] c_unjam_inc;
    logic          c_unjam_done;

    assign c_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || c_advance;
    assign c_in_take  = i_in_valid && o_in_ready;

    always_comb begin
        c_burst_arm = r_in_burst && r_in_armed;
        c_fire_inc  = (r_fire_timer == {CW{1'b1}}) ? r_fire_timer : r_fire_timer + 1'b1;
        c_fire      = c_burst_arm
                      && (CMP_W'(c_fire_inc) >= CMP_W'(cfg.fire_period_ticks));
        c_trig_now  = r_in_shot || (c_fire && (r_phase == fss_pkg::PH_IDLE));
        c_pend_tmr  = c_burst_arm && (r_pending || (c_fire && (r_phase != fss_pkg::PH_IDLE)));
        c_run_ok    = r_in_armed && r_in_friction;

        c_spd_mag = r_in_speed[SW-1] ? SW'(-r_in_speed) : r_in_speed;
        c_err     = r_target - r_in_position;
        c_err_x   = {c_err[PW-1], c_err};
        c_tol_x   = {2'b00, cfg.position_tolerance};
        c_tol_neg = -c_tol_x;
        c_arrive  = (c_err_x < c_tol_x) && (c_err_x > c_tol_neg)
                    && (c_spd_mag < {1'b0, cfg.speed_tolerance});

        c_stall_inc  = (r_stall == {CW{1'b1}}) ? r_stall : r_stall + 1'b1;
        c_stall_next = (c_spd_mag < {1'b0, cfg.jam_speed_limit}) ? c_stall_inc : '0;
        c_jam        = CMP_W'(c_stall_next) >= CMP_W'(cfg.jam_dwell);

        c_unjam_inc  = (r_unjam == {CW{1'b1}}) ? r_unjam : r_unjam + 1'b1;
        c_unjam_done = CMP_W'(c_unjam_inc) >= CMP_W'(cfg.unjam_span);
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_fire_timer = (c_burst_arm && !c_fire) ? c_fire_inc : '0;
        n_pending    = c_pend_tmr;
        n_stall      = r_stall;
        n_unjam      = r_unjam;
        if (r_in_disarm) begin
            n_phase      = fss_pkg::PH_IDLE;
            n_target     = '0;
            n_fire_timer = '0;
            n_pending    = 1'b0;
            n_stall      = '0;
            n_unjam      = '0;
        end else begin
            case (r_phase)
                fss_pkg::PH_IDLE: begin
                    n_stall = '0;
                    if (!c_run_ok) begin
                        n_target = r_in_position;
                    end else begin
                        if (!c_trig_now && c_pend_tmr) begin
                            n_pending = 1'b0;
                        end
                        if (c_trig_now || c_pend_tmr) begin
                            n_target = r_target + {1'b0, cfg.feed_step};
                            n_phase  = fss_pkg::PH_FEED;
                        end
                    end
                end
                fss_pkg::PH_FEED: begin
                    if (c_arrive) begin
                        n_phase = fss_pkg::PH_IDLE;
                        n_stall = '0;
                    end else if (c_jam) begin
                        n_stall = '0;
                        n_unjam = '0;
                        n_phase = fss_pkg::PH_UNJAM;
                    end else begin
                        n_stall = c_stall_next;
                    end
                end
                default: begin
                    n_phase = fss_pkg::PH_UNJAM;
                    if (c_unjam_done) begin
                        n_unjam = '0;
                        n_phase = fss_pkg::PH_FEED;
                    end else begin
                        n_unjam = c_unjam_inc;
                    end
                end
            endcase
        end
    end

    // command for this item
    always_comb begin
        n_out_mode   = fss_pkg::DM_ZERO;
        n_out_target = '0;
        if (!r_in_disarm) begin
            case (r_phase)
                fss_pkg::PH_IDLE: begin
                    if (!c_run_ok) begin
                        n_out_mode = fss_pkg::DM_ZERO;
                    end else if (c_trig_now || c_pend_tmr) begin
                        n_out_mode = fss_pkg::DM_NONE;
                    end else begin
                        n_out_mode   = fss_pkg::DM_HOLD;
                        n_out_target = r_target;
                    end
                end
                fss_pkg::PH_FEED: begin
                    n_out_mode   = fss_pkg::DM_HOLD;
                    n_out_target = r_target;
                end
                default: begin
                    n_out_mode = fss_pkg::DM_UNJAM;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= fss_pkg::PH_IDLE;
            r_target     <= '0;
            r_fire_timer <= '0;
            r_pending    <= 1'b0;
            r_stall      <= '0;
            r_unjam      <= '0;
        end else begin
            if (c_in_take) begin
                r_in_valid <= 1'b1;
            end else if (c_advance) begin
                r_in_valid <= 1'b0;
            end
            if (c_advance) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_target     <= n_target;
                r_fire_timer <= n_fire_timer;
                r_pending    <= n_pending;
                r_stall      <= n_stall;
                r_unjam      <= n_unjam;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_in_take) begin
            r_in_disarm   <= i_disarm;
            r_in_friction <= i_friction_on;
            r_in_armed    <= i_feeder_armed;
            r_in_shot     <= i_shot_request;
            r_in_burst    <= i_burst_enable;
            r_in_position <= i_measured_position;
            r_in_speed    <= i_measured_speed;
        end
        if (c_advance) begin
            r_out_mode   <= n_out_mode;
            r_out_target <= n_out_target;
            r_out_wheels <= r_in_friction && !r_in_disarm;
            r_out_state  <= n_phase;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_mode   = r_out_mode;
    assign o_drive_target = r_out_target;
    assign o_wheels_run   = r_out_wheels;
    assign o_seq_state    = r_out_state;

    `FSS_ASSERT_NEXT(a_disarm_clears, i_clk, i_rst_n, c_advance && r_in_disarm,
        r_out_valid && (r_phase == fss_pkg::PH_IDLE) && (r_out_mode == fss_pkg::DM_ZERO)
        && (r_out_target == '0), "disarm item did not clear the sequencer")
    `FSS_ASSERT_NOW(a_unjam_count_idle, i_clk, i_rst_n, r_phase != fss_pkg::PH_UNJAM,
        r_unjam == '0, "unjam counter running outside unjamming")
    `FSS_ASSERT_NOW(a_stall_idle, i_clk, i_rst_n, r_phase == fss_pkg::PH_IDLE,
        r_stall == '0, "stall counter running while idle")
    `FSS_ASSERT_NOW(a_target_only_hold, i_clk, i_rst_n,
        r_out_valid && (r_out_mode != fss_pkg::DM_HOLD),
        r_out_target == '0, "target shown outside hold mode")

endmodule

@@ rtl/fss_cfg_regs.sv @@
module fss_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fss_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output fss_pkg::t_cfg                       o_cfg
);

    fss_pkg::t_cfg      r_cfg;
    fss_pkg::t_cfg      n_cfg;
    fss_pkg::t_cfg_index c_index;

    assign c_index = fss_pkg::t_cfg_index'(i_cfg_index);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (c_index)
                fss_pkg::CFG_FIRE_PERIOD_TICKS:
                    n_cfg.fire_period_ticks = i_cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_FEED_STEP:
                    n_cfg.feed_step = i_cfg_data[30:0];
                fss_pkg::CFG_POSITION_TOLERANCE:
                    n_cfg.position_tolerance = i_cfg_data[30:0];
                fss_pkg::CFG_SPEED_TOLERANCE:
                    n_cfg.speed_tolerance = i_cfg_data[14:0];
                fss_pkg::CFG_JAM_SPEED_LIMIT:
                    n_cfg.jam_speed_limit = i_cfg_data[14:0];
                fss_pkg::CFG_JAM_DWELL:
                    n_cfg.jam_dwell = i_cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_UNJAM_SPAN:
                    n_cfg.unjam_span = i_cfg_data[fss_pkg::THR_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fire_period_ticks  <= fss_pkg::FIRE_PERIOD_TICKS_RST;
            r_cfg.feed_step          <= fss_pkg::FEED_STEP_RST;
            r_cfg.position_tolerance <= fss_pkg::POSITION_TOLERANCE_RST;
            r_cfg.speed_tolerance    <= fss_pkg::SPEED_TOLERANCE_RST;
            r_cfg.jam_speed_limit    <= fss_pkg::JAM_SPEED_LIMIT_RST;
            r_cfg.jam_dwell          <= fss_pkg::JAM_DWELL_RST;
            r_cfg.unjam_span         <= fss_pkg::UNJAM_SPAN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
